// ===== rtl/tma_pkg.sv =====
// ----------------------------------------------------------------------------
// tma_pkg: shared types and constants of the trimmed moving average
// Sample and payload types, the register width and the command bundle that
// the controller hands to the datapath.
// ----------------------------------------------------------------------------
package tma_pkg;

   // fixed field widths
   localparam int SAMPLE_W     = 16;
   localparam int CFG_W        = 5;
   localparam int NUM_CH       = 3;

   // window rules
   localparam int MIN_WINDOW   = 3;
   localparam int DROP_COUNT   = 2;
   localparam int RESET_WINDOW = 8;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // one sample per channel, packed in the order of the payload fields
   typedef sample_type [NUM_CH-1:0] sample_vec_type;

   typedef struct packed {
      sample_type hfov_in;
      sample_type vfov_in;
      sample_type dfov_in;
   } req_payload_type;

   typedef struct packed {
      sample_type hfov_avg;
      sample_type vfov_avg;
      sample_type dfov_avg;
   } rsp_payload_type;

   typedef logic [CFG_W-1:0] csr_payload_type;

   // controller to datapath commands
   typedef struct packed {
      logic write;      // store the accepted request in the buffer
      logic accum;      // fold the buffer read data into the running sums
      logic seed;       // first entry of the walk: restart sum and extremes
      logic load_div;   // load the divider with the (trimmed) sum
      logic full;       // window full: drop largest and smallest
      logic div_step;   // one restoring divide step
      logic publish;    // move the quotients into the result register
   } dp_cmd_type;

endpackage

// ===== rtl/tma_stream_if.sv =====
// ----------------------------------------------------------------------------
// tma_stream_if: valid/ready channel
// Carries one payload per handshake; used for requests, results and the
// window length register write.
// ----------------------------------------------------------------------------
interface tma_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/tma_ram.sv =====
// ----------------------------------------------------------------------------
// tma_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tma_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tma_ctrl.sv =====
// ----------------------------------------------------------------------------
// tma_ctrl: sequencer of the trimmed moving average
// Holds the window length, ring write pointer and fill count, and steps the
// datapath through store, buffer walk, trim, divide and publish.
// ----------------------------------------------------------------------------
module tma_ctrl #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 csr_valid,
   input  tma_pkg::csr_payload_type             csr_data,
   output logic                                 csr_ready,
   input  logic                                 out_busy,
   output tma_pkg::dp_cmd_type                  cmd,
   output logic [$clog2(MAX_WINDOW)-1:0]        wr_addr,
   output logic [$clog2(MAX_WINDOW)-1:0]        rd_addr,
   output logic [$clog2(MAX_WINDOW+1)-1:0]      divisor
);
   import tma_pkg::*;

   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SAMPLE_W + IDX_W;
   localparam int BIT_W = $clog2(SUM_W + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_WALK   = 5'b00010,
      ST_TRIM   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_DONE   = 5'b10000
   } ctrl_state_type;

   ctrl_state_type   state_ff,   state_in;
   logic [LEN_W-1:0] win_len_ff, win_len_in;
   logic [IDX_W-1:0] wr_idx_ff,  wr_idx_in;
   logic [LEN_W-1:0] fill_ff,    fill_in;
   logic             full_ff,    full_in;
   logic [LEN_W-1:0] rd_cnt_ff,  rd_cnt_in;
   logic [BIT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [LEN_W-1:0] fill_next;

   // register writes are always taken
   assign csr_ready = 1'b1;

   assign wr_addr = wr_idx_ff;
   assign rd_addr = rd_cnt_ff[IDX_W-1:0];
   assign divisor = full_ff ? (win_len_ff - LEN_W'(DROP_COUNT)) : fill_ff;

   // fill count after storing one more entry, saturating at the window length
   assign fill_next = (fill_ff < win_len_ff) ? (fill_ff + LEN_W'(1)) : fill_ff;

   // next state and command decode
   always_comb begin
      state_in   = state_ff;
      win_len_in = win_len_ff;
      wr_idx_in  = wr_idx_ff;
      fill_in    = fill_ff;
      full_in    = full_ff;
      rd_cnt_in  = rd_cnt_ff;
      bit_cnt_in = bit_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.write = 1'b1;
               fill_in   = fill_next;
               full_in   = (fill_next == win_len_ff);
               if ((LEN_W'(wr_idx_ff) + LEN_W'(1)) == win_len_ff) begin
                  wr_idx_in = '0;
               end else begin
                  wr_idx_in = wr_idx_ff + IDX_W'(1);
               end
               rd_cnt_in = '0;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            // read data is registered and arrives in the cycle after its address
            cmd.accum = (rd_cnt_ff != '0);
            cmd.seed  = (rd_cnt_ff == LEN_W'(1));
            rd_cnt_in = rd_cnt_ff + LEN_W'(1);
            if (rd_cnt_ff == fill_ff) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            cmd.load_div = 1'b1;
            cmd.full     = full_ff;
            bit_cnt_in   = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            bit_cnt_in   = bit_cnt_ff + BIT_W'(1);
            if (bit_cnt_ff == BIT_W'(SUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_busy) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // window length write: saturate and empty the window
      if (csr_valid) begin
         if (32'(csr_data) < 32'(MIN_WINDOW)) begin
            win_len_in = LEN_W'(MIN_WINDOW);
         end else if (32'(csr_data) > 32'(MAX_WINDOW)) begin
            win_len_in = LEN_W'(MAX_WINDOW);
         end else begin
            win_len_in = LEN_W'(csr_data);
         end
         wr_idx_in = '0;
         fill_in   = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         win_len_ff <= LEN_W'(RESET_WINDOW);
         wr_idx_ff  <= '0;
         fill_ff    <= '0;
         full_ff    <= 1'b0;
         rd_cnt_ff  <= '0;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         win_len_ff <= win_len_in;
         wr_idx_ff  <= wr_idx_in;
         fill_ff    <= fill_in;
         full_ff    <= full_in;
         rd_cnt_ff  <= rd_cnt_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

endmodule

// ===== rtl/tma_dpath.sv =====
// ----------------------------------------------------------------------------
// tma_dpath: datapath of the trimmed moving average
// Sample buffer, per-channel sum and extreme tracking, bit-serial dividers
// and the result register.
// ----------------------------------------------------------------------------
module tma_dpath #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tma_pkg::dp_cmd_type             cmd,
   input  logic [$clog2(MAX_WINDOW)-1:0]   wr_addr,
   input  logic [$clog2(MAX_WINDOW)-1:0]   rd_addr,
   input  logic [$clog2(MAX_WINDOW+1)-1:0] divisor,
   input  tma_pkg::req_payload_type        req_data,
   output tma_pkg::rsp_payload_type        rsp_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            out_busy
);
   import tma_pkg::*;

   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SAMPLE_W + IDX_W;
   localparam int BUF_W = NUM_CH * SAMPLE_W;

   logic [BUF_W-1:0] ram_wr_data;
   logic [BUF_W-1:0] ram_rd_data;
   sample_vec_type   rd_vec;
   sample_vec_type   res_vec;

   logic [SUM_W-1:0] sum_ff [NUM_CH];
   logic [SUM_W-1:0] sum_in [NUM_CH];
   sample_type       hi_ff  [NUM_CH];
   sample_type       hi_in  [NUM_CH];
   sample_type       lo_ff  [NUM_CH];
   sample_type       lo_in  [NUM_CH];
   logic [SUM_W-1:0] dvd_ff [NUM_CH];
   logic [SUM_W-1:0] dvd_in [NUM_CH];
   logic [LEN_W-1:0] rem_ff [NUM_CH];
   logic [LEN_W-1:0] rem_in [NUM_CH];
   logic [LEN_W:0]   shifted [NUM_CH];
   logic             fits   [NUM_CH];
   logic [LEN_W-1:0] div_ff, div_in;

   rsp_payload_type  rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // sample buffer, one row holds all three channels
   assign ram_wr_data = req_data;

   tma_ram #(
      .WIDTH (BUF_W),
      .DEPTH (MAX_WINDOW)
   ) u_buf (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_vec = ram_rd_data;

   // divisor latched with the dividend
   assign div_in = cmd.load_div ? divisor : div_ff;

   // per-channel accumulate, trim and restoring divide
   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         sum_in[k]  = sum_ff[k];
         hi_in[k]   = hi_ff[k];
         lo_in[k]   = lo_ff[k];
         dvd_in[k]  = dvd_ff[k];
         rem_in[k]  = rem_ff[k];
         shifted[k] = {rem_ff[k], dvd_ff[k][SUM_W-1]};
         fits[k]    = (shifted[k] >= {1'b0, div_ff});

         if (cmd.accum) begin
            if (cmd.seed) begin
               sum_in[k] = SUM_W'(rd_vec[k]);
               hi_in[k]  = rd_vec[k];
               lo_in[k]  = rd_vec[k];
            end else begin
               sum_in[k] = sum_ff[k] + SUM_W'(rd_vec[k]);
               if (rd_vec[k] > hi_ff[k]) begin
                  hi_in[k] = rd_vec[k];
               end
               if (rd_vec[k] < lo_ff[k]) begin
                  lo_in[k] = rd_vec[k];
               end
            end
         end

         if (cmd.load_div) begin
            if (cmd.full) begin
               dvd_in[k] = sum_ff[k] - (SUM_W'(hi_ff[k]) + SUM_W'(lo_ff[k]));
            end else begin
               dvd_in[k] = sum_ff[k];
            end
            rem_in[k] = '0;
         end else if (cmd.div_step) begin
            dvd_in[k] = {dvd_ff[k][SUM_W-2:0], fits[k]};
            if (fits[k]) begin
               rem_in[k] = LEN_W'(shifted[k] - {1'b0, div_ff});
            end else begin
               rem_in[k] = shifted[k][LEN_W-1:0];
            end
         end

         res_vec[k] = dvd_ff[k][SAMPLE_W-1:0];
      end
   end

   // result register, free once the result is taken
   assign out_busy     = rsp_valid_ff && !rsp_ready;
   assign rsp_valid_in = cmd.publish || out_busy;
   assign rsp_data_in  = cmd.publish ? rsp_payload_type'(res_vec) : rsp_data_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_CH; k++) begin
         sum_ff[k] <= sum_in[k];
         hi_ff[k]  <= hi_in[k];
         lo_ff[k]  <= lo_in[k];
         dvd_ff[k] <= dvd_in[k];
         rem_ff[k] <= rem_in[k];
      end
      div_ff      <= div_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/trimmed_moving_average_3ch_top.sv =====
// ----------------------------------------------------------------------------
// trimmed_moving_average_3ch_top: three-channel trimmed moving average
// Smooths horizontal, vertical and diagonal angle samples over a window.
// ----------------------------------------------------------------------------
// Each request carries three Q8.8 angle samples, which are stored in a ring
// buffer of window_len rows (3 to MAX_WINDOW, reset 8); each request gives one
// response holding the per-channel mean of the stored rows, rounded down.
// While the window fills the divisor is the number of rows stored; once full,
// one largest and one smallest value per channel are dropped and the rest is
// divided by window_len - 2. A write on the csr channel sets the window length
// (saturated to 3..MAX_WINDOW) and empties the window. After a request is
// accepted, the buffer RAM is walked one row per cycle over the rows stored
// so far, then a bit-serial divider per channel retires one quotient bit per
// cycle. A new request is taken as soon as the previous response sits in the
// output register.
// ----------------------------------------------------------------------------
module trimmed_moving_average_3ch_top #(
   parameter int MAX_WINDOW = 16
) (
   input logic          clock,
   input logic          reset,
   tma_stream_if.sink   req_if,
   tma_stream_if.source rsp_if,
   tma_stream_if.sink   csr_if
);
   import tma_pkg::*;

   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);

   dp_cmd_type       cmd;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic [LEN_W-1:0] divisor;
   logic             out_busy;

   // sequencer
   tma_ctrl #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .csr_valid (csr_if.valid),
      .csr_data  (csr_if.payload),
      .csr_ready (csr_if.ready),
      .out_busy  (out_busy),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .divisor   (divisor)
   );

   // buffer, sums and dividers
   tma_dpath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .divisor   (divisor),
      .req_data  (req_if.payload),
      .rsp_data  (rsp_if.payload),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .out_busy  (out_busy)
   );

endmodule

// ===== verif/tb_trimmed_moving_average_3ch_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trimmed_moving_average_3ch_top: angle smoothing window testbench
// Drives angle triples and window length writes into the block and checks
// every smoothed triple against a ring buffer model or a scripted golden
// value. A short scripted part covers window saturation, extreme samples and
// ties; random phases follow with bursty requests and a stalling result sink.
// ----------------------------------------------------------------------------
module tb_trimmed_moving_average_3ch_top;

   import tma_pkg::*;

   localparam int          MAX_WIN       = 16;
   localparam int unsigned FOV_MAX_Q88   = 46080;
   localparam int          RAND_ITEMS    = 650;
   localparam int          SETTLE_CYCLES = 64;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          SCRIPT_ROWS   = 24;

   typedef enum logic {ROW_REQ, ROW_CSR} script_kind_type;
   typedef enum {RSP_FREE, RSP_RANDOM, RSP_PATTERN} rsp_mode_type;

   typedef struct packed {
      script_kind_type kind;
      csr_payload_type csr_val;
      req_payload_type req;
      logic            golden_on;
      rsp_payload_type golden;
   } script_row_type;

   logic clock;
   logic reset;

   tma_stream_if #(.payload_type(req_payload_type)) req_ch ();
   tma_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();
   tma_stream_if #(.payload_type(csr_payload_type)) csr_ch ();

   trimmed_moving_average_3ch_top #(.MAX_WINDOW(MAX_WIN)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // window model state
   sample_type  fov_hist [NUM_CH][MAX_WIN];
   int unsigned win_len   = RESET_WINDOW;
   int unsigned hist_wr   = 0;
   int unsigned hist_fill = 0;

   rsp_payload_type fov_expect_q [$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              sent_total     = 0;

   // sender and sink pacing
   bit           gaps_on    = 1'b1;
   int           burst_left = 0;
   rsp_mode_type rsp_mode   = RSP_FREE;
   bit [15:0]    stall_pat  = 16'hC3A5;
   bit [3:0]     stall_tick = '0;
   sample_type   last_angle [NUM_CH] = '{default: '0};

   // scripted requests: saturation of the window length, extremes, ties
   script_row_type fov_script [SCRIPT_ROWS] = '{
      '{ROW_REQ, 5'd0,  {16'h1234, 16'hB400, 16'h0000}, 1'b1, {16'h1234, 16'hB400, 16'h0000}},
      '{ROW_REQ, 5'd0,  {16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, 48'h0},
      '{ROW_REQ, 5'd0,  {16'h0000, 16'h0000, 16'h0000}, 1'b0, 48'h0},
      '{ROW_CSR, 5'd0,  48'h0, 1'b0, 48'h0},
      '{ROW_REQ, 5'd0,  {16'h0000, 16'h0000, 16'h0000}, 1'b1, {16'h0000, 16'h0000, 16'h0000}},
      '{ROW_REQ, 5'd0,  {16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, {16'h7FFF, 16'h7FFF, 16'h7FFF}},
      '{ROW_REQ, 5'd0,  {16'hB400, 16'h0001, 16'h8000}, 1'b1, {16'hB400, 16'h0001, 16'h8000}},
      '{ROW_REQ, 5'd0,  {16'h0007, 16'h0007, 16'h0007}, 1'b1, {16'hB400, 16'h0007, 16'h8000}},
      '{ROW_CSR, 5'd31, 48'h0, 1'b0, 48'h0},
      '{ROW_REQ, 5'd0,  {16'h0100, 16'h0200, 16'h0300}, 1'b1, {16'h0100, 16'h0200, 16'h0300}},
      '{ROW_REQ, 5'd0,  {16'h0300, 16'h0200, 16'h0100}, 1'b1, {16'h0200, 16'h0200, 16'h0200}},
      '{ROW_REQ, 5'd0,  {16'hAAAA, 16'h5555, 16'hB401}, 1'b0, 48'h0},
      '{ROW_REQ, 5'd0,  {16'h5555, 16'hAAAA, 16'hFFFE}, 1'b0, 48'h0},
      '{ROW_CSR, 5'd2,  48'h0, 1'b0, 48'h0},
      '{ROW_REQ, 5'd0,  {16'h4000, 16'h0000, 16'hAAAA}, 1'b1, {16'h4000, 16'h0000, 16'hAAAA}},
      '{ROW_REQ, 5'd0,  {16'h4000, 16'h0000, 16'hAAAA}, 1'b1, {16'h4000, 16'h0000, 16'hAAAA}},
      '{ROW_REQ, 5'd0,  {16'h4000, 16'h0000, 16'hAAAA}, 1'b1, {16'h4000, 16'h0000, 16'hAAAA}},
      '{ROW_REQ, 5'd0,  {16'h4000, 16'hFFFF, 16'h0001}, 1'b1, {16'h4000, 16'h0000, 16'hAAAA}},
      '{ROW_CSR, 5'd3,  48'h0, 1'b0, 48'h0},
      '{ROW_REQ, 5'd0,  {16'hB400, 16'hB400, 16'hB400}, 1'b1, {16'hB400, 16'hB400, 16'hB400}},
      '{ROW_CSR, 5'd16, 48'h0, 1'b0, 48'h0},
      '{ROW_REQ, 5'd0,  {16'h0001, 16'h8000, 16'hFFFF}, 1'b1, {16'h0001, 16'h8000, 16'hFFFF}},
      '{ROW_CSR, 5'd1,  48'h0, 1'b0, 48'h0},
      '{ROW_REQ, 5'd0,  {16'h0000, 16'hFFFF, 16'hB400}, 1'b1, {16'h0000, 16'hFFFF, 16'hB400}}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // window length write: saturate and empty the window
   function automatic void set_window(csr_payload_type val);
      win_len = 32'(val);
      if (win_len < MIN_WINDOW) win_len = MIN_WINDOW;
      if (win_len > MAX_WIN) win_len = MAX_WIN;
      hist_wr   = 0;
      hist_fill = 0;
   endfunction

   // store one triple and return the trimmed per-channel means
   function automatic rsp_payload_type advance_window(req_payload_type p);
      sample_type      smp [NUM_CH];
      sample_type      avg [NUM_CH];
      int unsigned     sum;
      int unsigned     hi;
      int unsigned     lo;
      int unsigned     divisor;
      bit              full;
      rsp_payload_type r;
      smp[0] = p.hfov_in;
      smp[1] = p.vfov_in;
      smp[2] = p.dfov_in;
      if (hist_fill < win_len) hist_fill++;
      for (int ch = 0; ch < NUM_CH; ch++) fov_hist[ch][hist_wr] = smp[ch];
      hist_wr = (hist_wr + 1) % win_len;
      full    = (hist_fill == win_len);
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum = 0;
         hi  = 32'(fov_hist[ch][0]);
         lo  = 32'(fov_hist[ch][0]);
         for (int i = 0; i < hist_fill; i++) begin
            sum += 32'(fov_hist[ch][i]);
            if (fov_hist[ch][i] > hi) hi = 32'(fov_hist[ch][i]);
            if (fov_hist[ch][i] < lo) lo = 32'(fov_hist[ch][i]);
         end
         if (full) begin
            sum     -= hi + lo;
            divisor  = win_len - DROP_COUNT;
         end else begin
            divisor = hist_fill;
         end
         avg[ch] = sample_type'(sum / divisor);
      end
      r.hfov_avg = avg[0];
      r.vfov_avg = avg[1];
      r.dfov_avg = avg[2];
      return r;
   endfunction

   // random angle, weighted toward corners and repeats of the last value
   function automatic sample_type pick_angle(int ch);
      sample_type a;
      case ($urandom_range(0, 9))
         0: a = '0;
         1: a = '1;
         2: a = sample_type'(FOV_MAX_Q88);
         3: a = last_angle[ch];
         4, 5: a = sample_type'($urandom);
         default: a = sample_type'($urandom_range(0, FOV_MAX_Q88));
      endcase
      last_angle[ch] = a;
      return a;
   endfunction

   // one request, with a random gap at the start of each burst
   task automatic send_fov(input req_payload_type p, input bit use_golden,
                           input rsp_payload_type golden);
      int gap;
      rsp_payload_type predicted;
      if (gaps_on && burst_left == 0) begin
         gap        = $urandom_range(0, 8);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= p;
      do @(posedge clock); while (!req_ch.ready);
      predicted = advance_window(p);
      fov_expect_q.push_back(use_golden ? golden : predicted);
   endtask

   // hold requests until every expected result has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (fov_expect_q.size() != 0) @(posedge clock);
   endtask

   // window length write, only with the block idle
   task automatic write_window(input csr_payload_type val);
      drain_results();
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      set_window(val);
   endtask

   // result sink stall pattern
   always @(posedge clock) begin
      stall_tick <= stall_tick + 4'd1;
      case (rsp_mode)
         RSP_FREE:   rsp_ch.ready <= 1'b1;
         RSP_RANDOM: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
         default: begin
            rsp_ch.ready <= stall_pat[stall_tick];
            if (stall_tick == 4'd15) stall_pat <= 16'($urandom);
         end
      endcase
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (fov_expect_q.size() == 0) begin
            $error("unexpected result %h", rsp_ch.payload);
            mismatch_count++;
         end else begin
            want = fov_expect_q.pop_front();
            if (rsp_ch.payload.hfov_avg !== want.hfov_avg) begin
               $error("hfov_avg: expected %h, got %h", want.hfov_avg, rsp_ch.payload.hfov_avg);
               mismatch_count++;
            end
            if (rsp_ch.payload.vfov_avg !== want.vfov_avg) begin
               $error("vfov_avg: expected %h, got %h", want.vfov_avg, rsp_ch.payload.vfov_avg);
               mismatch_count++;
            end
            if (rsp_ch.payload.dfov_avg !== want.dfov_avg) begin
               $error("dfov_avg: expected %h, got %h", want.dfov_avg, rsp_ch.payload.dfov_avg);
               mismatch_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      int              phase;
      int              n_items;
      csr_payload_type win_sel;
      req_payload_type rnd_req;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // scripted part
      rsp_mode = RSP_PATTERN;
      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         if (fov_script[r].kind == ROW_CSR) write_window(fov_script[r].csr_val);
         else send_fov(fov_script[r].req, fov_script[r].golden_on, fov_script[r].golden);
      end

      // random phases, extremes of the window length first
      phase = 0;
      while (sent_total < RAND_ITEMS) begin
         case (phase)
            0: win_sel = 5'd3;
            1: win_sel = 5'd16;
            2: win_sel = 5'd31;
            3: win_sel = 5'd0;
            default: win_sel = csr_payload_type'($urandom_range(0, 31));
         endcase
         if (phase < 4 || $urandom_range(0, 3) != 0) write_window(win_sel);
         gaps_on  = (phase != 1) && ($urandom_range(0, 3) != 0);
         rsp_mode = (phase == 1) ? RSP_FREE : rsp_mode_type'($urandom_range(0, 2));
         n_items  = $urandom_range(30, 80);
         if (n_items > RAND_ITEMS - sent_total) n_items = RAND_ITEMS - sent_total;
         for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2 && phase % 3 == 2) drain_results();
            rnd_req.hfov_in = pick_angle(0);
            rnd_req.vfov_in = pick_angle(1);
            rnd_req.dfov_in = pick_angle(2);
            send_fov(rnd_req, 1'b0, '0);
            sent_total++;
         end
         phase++;
      end

      // wind down
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
